>>> rtl/reliable_packet_ack_tracker_assert.svh
// Assertion macros used by the ack tracker checker.
`ifndef RELIABLE_PACKET_ACK_TRACKER_ASSERT_SVH
`define RELIABLE_PACKET_ACK_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RPAT_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("ack tracker check failed");

// Next-cycle implication, disabled while in reset.
`define RPAT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("ack tracker check failed");

`endif

>>> rtl/rpat_pkg.sv
// Types, constants and codes of the reliable packet ack tracker.
package rpat_pkg;
	localparam int ID_WIDTH       = 8;
	localparam int HANDLE_WIDTH   = 8;
	localparam int ACK_BITS       = 32;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_COUNT       = 1 << ID_WIDTH;
	localparam int ACK_IDX_W      = $clog2(ACK_BITS);
	localparam int ACK_CNT_W      = $clog2(ACK_BITS + 1);
	localparam int HALF_ID        = (ID_COUNT - 1) / 2;

	typedef logic [ID_WIDTH-1:0]     id_t;
	typedef logic [HANDLE_WIDTH-1:0] handle_t;

	localparam id_t ID_MAX  = id_t'(ID_COUNT - 1);
	localparam id_t ID_ZERO = id_t'(0);
	localparam id_t ID_ONE  = id_t'(1);

	// Item commands
	localparam logic [1:0] CMD_SCHEDULE = 2'd0;
	localparam logic [1:0] CMD_POP_OUT  = 2'd1;
	localparam logic [1:0] CMD_RECEIVE  = 2'd2;
	localparam logic [1:0] CMD_POP_IN   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Configuration register indexes
	localparam logic REG_IN_START  = 1'b0;
	localparam logic REG_OUT_START = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  buffer_handle;
		logic        is_reliable;
		logic [7:0]  rx_packet_id;
		logic [7:0]  rx_ack_id;
		logic [31:0] rx_ack_bits;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_handle;
		logic [7:0]  out_packet_id;
		logic        out_reliable;
		logic [7:0]  tx_ack_id;
		logic [31:0] tx_ack_bits;
	} out_item_t;

	// One queue entry
	typedef struct packed {
		handle_t handle;
		id_t     id;
		logic    reliable;
	} pkt_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic sched;
		logic opop;
		logic bits_step;
		logic ack_init;
		logic ack_step;
		logic ack_push;
		logic unrel_push;
		logic rx_store;
		logic rel_step;
		logic rel_push;
		logic ipop;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] command;
		logic       reliable;
		logic       rid_nz;
		logic       oq_empty;
		logic       iq_empty;
		logic       ack_need_push;
		logic       walk_last;
		logic       walk_done;
		logic       rel_stop;
	} dp_stat_t;
endpackage

>>> rtl/reliable_packet_ack_tracker.sv
// Top level of the reliable packet ack tracker.
//
// channel | signals                                  | transfer when
// --------+------------------------------------------+------------------------
// in      | in_valid, in_ready, in_data              | in_valid && in_ready
// out     | out_valid, out_ready, out_data           | out_valid && out_ready
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//
// One item at a time. Schedule and pop incoming run their command state,
// then give the result; pop outgoing walks the ack header one id a cycle.
// Receive walks the partner's ack header, requeueing each unacked id, then
// pushes an unreliable packet, or stores a reliable packet with a nonzero id
// and releases ids in order (release walk, one id per pass).
// The result holds in its register until out_ready; in_ready stays low meanwhile.
// Reset clears valid bits and queues at once; no clearing pass.
module reliable_packet_ack_tracker #(
	parameter int QUEUE_DEPTH = rpat_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rpat_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rpat_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);
	import rpat_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	rpat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	rpat_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat), .out_data(out_data)
	);
endmodule

>>> rtl/rpat_fifo.sv
// Packet queue: memory with head and tail pointers and a fill count.
module rpat_fifo #(
	parameter int DEPTH = rpat_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rpat_pkg::pkt_t wdata,
	input  logic          pop,
	output rpat_pkg::pkt_t rdata,
	output logic          full,
	output logic          empty
);
	import rpat_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pkt_t mem [DEPTH];
	pkt_t rd_q;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = rd_q;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries, register the popped one
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= wdata;
		end
		if (do_pop) begin
			rd_q <= mem[head_q];
		end
	end
endmodule

>>> rtl/rpat_datapath.sv
// Datapath: counters, id stores, ack walk, release walk and both queues.
module rpat_datapath #(
	parameter int QUEUE_DEPTH = rpat_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rpat_pkg::in_item_t  in_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  rpat_pkg::ctrl_cmd_t cmd,
	output rpat_pkg::dp_stat_t  stat,
	output rpat_pkg::out_item_t out_data
);
	import rpat_pkg::*;

	in_item_t item_q;
	id_t out_cnt_q, in_cnt_q, latest_q, walk_q, rel_q, ack_id_q;
	logic [ID_COUNT-1:0] rt_valid_q, rx_valid_q;
	logic [ACK_CNT_W-1:0] idx_q;
	logic [ACK_BITS-1:0] bits_q;
	logic [1:0] stat_q;
	logic pop_ok_q, src_in_q;
	handle_t rt_mem [ID_COUNT];
	handle_t rx_mem [ID_COUNT];
	handle_t rt_rd_q, rx_rd_q;

	id_t rid, aid, walk_prev, next_out_id, rel_cand, latest_upd;
	handle_t hdl;
	logic ack_bit;
	pkt_t oq_wdata, iq_wdata, oq_rd, iq_rd;
	logic oq_full, oq_empty, iq_full, iq_empty;

	assign rid         = id_t'(item_q.rx_packet_id);
	assign aid         = id_t'(item_q.rx_ack_id);
	assign hdl         = handle_t'(item_q.buffer_handle);
	assign walk_prev   = walk_q - ID_ONE;
	assign next_out_id = (out_cnt_q == ID_MAX) ? ID_ONE : out_cnt_q + ID_ONE;
	assign rel_cand    = (rel_q + ID_ONE == ID_ZERO) ? ID_ONE : rel_q + ID_ONE;
	assign ack_bit     = item_q.rx_ack_bits[idx_q[ACK_IDX_W-1:0]];

	// Take the received id as latest if none is held yet or it is newer within half the id range
	always_comb begin
		logic newer;
		id_t span;
		newer = (rid >= latest_q);
		span  = newer ? rid - latest_q : latest_q - rid;
		latest_upd = latest_q;
		if (latest_q == ID_ZERO) begin
			latest_upd = rid;
		end else if ((newer && span < id_t'(HALF_ID)) || (!newer && span > id_t'(HALF_ID))) begin
			latest_upd = rid;
		end
	end

	// Queue write data
	always_comb begin
		if (cmd.ack_push) begin
			oq_wdata = '{handle: rt_rd_q, id: walk_q, reliable: 1'b1};
		end else if (item_q.is_reliable) begin
			oq_wdata = '{handle: hdl, id: next_out_id, reliable: 1'b1};
		end else begin
			oq_wdata = '{handle: hdl, id: ID_ZERO, reliable: 1'b0};
		end
		if (cmd.rel_push) begin
			iq_wdata = '{handle: rx_rd_q, id: rel_q, reliable: 1'b1};
		end else begin
			iq_wdata = '{handle: hdl, id: rid, reliable: 1'b0};
		end
	end

	rpat_fifo #(.DEPTH(QUEUE_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.push((cmd.sched && !oq_full) || cmd.ack_push), .wdata(oq_wdata),
		.pop(cmd.opop), .rdata(oq_rd), .full(oq_full), .empty(oq_empty)
	);

	rpat_fifo #(.DEPTH(QUEUE_DEPTH)) u_in_q (
		.clk(clk), .arst_n(arst_n),
		.push(cmd.unrel_push || cmd.rel_push), .wdata(iq_wdata),
		.pop(cmd.ipop), .rdata(iq_rd), .full(iq_full), .empty(iq_empty)
	);

	// Control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q  <= '0;
			in_cnt_q   <= '0;
			latest_q   <= '0;
			rt_valid_q <= '0;
			rx_valid_q <= '0;
			walk_q     <= '0;
			rel_q      <= '0;
			ack_id_q   <= '0;
			idx_q      <= '0;
			bits_q     <= '0;
			stat_q     <= ST_OK;
			pop_ok_q   <= 1'b0;
			src_in_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_IN_START) begin
					in_cnt_q <= id_t'(cfg_data);
				end else begin
					out_cnt_q <= id_t'(cfg_data);
				end
			end
			if (cmd.load) begin
				stat_q   <= ST_OK;
				pop_ok_q <= 1'b0;
			end
			// Schedule outgoing
			if (cmd.sched) begin
				if (oq_full) begin
					stat_q <= ST_FULL;
				end else if (item_q.is_reliable) begin
					out_cnt_q <= next_out_id;
					rt_valid_q[next_out_id] <= 1'b1;
				end
			end
			// Pop outgoing, start the ack header walk
			if (cmd.opop) begin
				if (oq_empty) begin
					stat_q <= ST_EMPTY;
				end else begin
					pop_ok_q <= 1'b1;
					src_in_q <= 1'b0;
					ack_id_q <= latest_q;
					walk_q   <= latest_q;
					idx_q    <= '0;
					bits_q   <= '0;
				end
			end
			if (cmd.bits_step) begin
				bits_q[idx_q[ACK_IDX_W-1:0]] <= rx_valid_q[walk_prev];
				walk_q <= walk_prev;
				idx_q  <= idx_q + 1'b1;
			end
			// Walk the partner's ack header
			if (cmd.ack_init) begin
				rt_valid_q[aid] <= 1'b0;
				walk_q <= aid;
				idx_q  <= '0;
			end
			if (cmd.ack_step) begin
				if (ack_bit) begin
					rt_valid_q[walk_prev] <= 1'b0;
				end
				walk_q <= walk_prev;
				idx_q  <= idx_q + 1'b1;
			end
			if (cmd.ack_push && oq_full) begin
				stat_q <= ST_FULL;
			end
			if ((cmd.unrel_push || cmd.rel_push) && iq_full) begin
				stat_q <= ST_FULL;
			end
			// Store the received packet, start the in-order release
			if (cmd.rx_store) begin
				latest_q <= latest_upd;
				rx_valid_q[rid] <= 1'b1;
				rel_q <= in_cnt_q;
			end
			if (cmd.rel_step) begin
				in_cnt_q <= rel_cand;
				rel_q    <= rel_cand;
			end
			// Pop incoming
			if (cmd.ipop) begin
				if (iq_empty) begin
					stat_q <= ST_EMPTY;
				end else begin
					pop_ok_q <= 1'b1;
					src_in_q <= 1'b1;
				end
			end
		end
	end

	// Item capture and handle stores
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.sched && !oq_full && item_q.is_reliable) begin
			rt_mem[next_out_id] <= hdl;
		end
		if (cmd.ack_step) begin
			rt_rd_q <= rt_mem[walk_prev];
		end
		if (cmd.rx_store) begin
			rx_mem[rid] <= hdl;
		end
		if (cmd.rel_step) begin
			rx_rd_q <= rx_mem[rel_cand];
		end
	end

	// Status to the controller
	always_comb begin
		stat.command       = item_q.command;
		stat.reliable      = item_q.is_reliable;
		stat.rid_nz        = (rid != ID_ZERO);
		stat.oq_empty      = oq_empty;
		stat.iq_empty      = iq_empty;
		stat.ack_need_push = !ack_bit && rt_valid_q[walk_prev];
		stat.walk_last     = (idx_q == ACK_CNT_W'(ACK_BITS - 1));
		stat.walk_done     = (idx_q == ACK_CNT_W'(ACK_BITS));
		stat.rel_stop      = (rel_q == latest_q) || !rx_valid_q[rel_cand];
	end

	// Result fields
	always_comb begin
		pkt_t p;
		p = src_in_q ? iq_rd : oq_rd;
		out_data.status        = stat_q;
		out_data.out_handle    = pop_ok_q ? 8'(p.handle) : '0;
		out_data.out_packet_id = pop_ok_q ? 8'(p.id) : '0;
		out_data.out_reliable  = pop_ok_q && p.reliable;
		out_data.tx_ack_id     = (pop_ok_q && !src_in_q) ? 8'(ack_id_q) : '0;
		out_data.tx_ack_bits   = (pop_ok_q && !src_in_q) ? 32'(bits_q) : '0;
	end
endmodule

>>> rtl/rpat_ctrl.sv
// Controller: sequences each item through the datapath.
module rpat_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rpat_pkg::dp_stat_t  stat,
	output rpat_pkg::ctrl_cmd_t cmd
);
	import rpat_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE   = 13'h0001,
		S_DECODE = 13'h0002,
		S_SCHED  = 13'h0004,
		S_OPOP   = 13'h0008,
		S_BITS   = 13'h0010,
		S_ACK    = 13'h0020,
		S_APUSH  = 13'h0040,
		S_UNREL  = 13'h0080,
		S_RXST   = 13'h0100,
		S_REL    = 13'h0200,
		S_RPUSH  = 13'h0400,
		S_IPOP   = 13'h0800,
		S_DONE   = 13'h1000
	} state_t;

	state_t state_q, state_d, after_ack;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	// Where a receive goes once its ack walk ends
	always_comb begin
		if (!stat.reliable) begin
			after_ack = S_UNREL;
		end else if (stat.rid_nz) begin
			after_ack = S_RXST;
		end else begin
			after_ack = S_DONE;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.command)
					CMD_SCHEDULE: state_d = S_SCHED;
					CMD_POP_OUT:  state_d = S_OPOP;
					CMD_RECEIVE: begin
						cmd.ack_init = 1'b1;
						state_d = S_ACK;
					end
					default:      state_d = S_IPOP;
				endcase
			end
			S_SCHED: begin
				cmd.sched = 1'b1;
				state_d   = S_DONE;
			end
			S_OPOP: begin
				cmd.opop = 1'b1;
				state_d  = stat.oq_empty ? S_DONE : S_BITS;
			end
			S_BITS: begin
				cmd.bits_step = 1'b1;
				state_d = stat.walk_last ? S_DONE : S_BITS;
			end
			S_ACK: begin
				cmd.ack_step = 1'b1;
				if (stat.ack_need_push) begin
					state_d = S_APUSH;
				end else if (stat.walk_last) begin
					state_d = after_ack;
				end
			end
			S_APUSH: begin
				cmd.ack_push = 1'b1;
				state_d = stat.walk_done ? after_ack : S_ACK;
			end
			S_UNREL: begin
				cmd.unrel_push = 1'b1;
				state_d = S_DONE;
			end
			S_RXST: begin
				cmd.rx_store = 1'b1;
				state_d = S_REL;
			end
			S_REL: begin
				if (stat.rel_stop) begin
					state_d = S_DONE;
				end else begin
					cmd.rel_step = 1'b1;
					state_d = S_RPUSH;
				end
			end
			S_RPUSH: begin
				cmd.rel_push = 1'b1;
				state_d = S_REL;
			end
			S_IPOP: begin
				cmd.ipop = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

>>> rtl/rpat_checker.sv
// Port-level checker for the ack tracker, bound to the top level.
`include "reliable_packet_ack_tracker_assert.svh"

module rpat_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input rpat_pkg::out_item_t out_data
);
	import rpat_pkg::*;

	// A waiting result holds
	`RPAT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))
	// No result in the cycle right after a transfer in
	`RPAT_ASSERT_NEXT(a_no_instant, clk, arst_n, in_valid && in_ready, !out_valid)
	// No new item while a result waits
	`RPAT_ASSERT_NOW(a_one_item, clk, arst_n, out_valid, !in_ready)
	// Failed or empty results carry no packet
	`RPAT_ASSERT_NOW(a_clean_fail, clk, arst_n, out_valid && out_data.status != ST_OK,
		out_data.out_handle == 8'd0 && out_data.tx_ack_bits == 32'd0)
endmodule

bind reliable_packet_ack_tracker rpat_checker u_rpat_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);
